// ===== rtl/hpq_pkg.sv =====
package hpq_pkg;

  // Operation codes carried in the op field
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } hpq_status_t;

  // What a token walking the level chain is doing
  typedef enum logic {
    MODE_INS = 1'b0,   // top-down insert along the path to the new slot
    MODE_DN  = 1'b1    // sift-down of the moved last key
  } hpq_mode_t;

  // Control half of a token handed from one level cell to the next
  typedef struct packed {
    logic      vld;
    hpq_mode_t mode;
  } hpq_ctl_t;

  // Position of the highest set bit (tree level of a one-based slot)
  function automatic logic [4:0] hpq_msb(input logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int b = 0; b < 32; b++) begin
      if (v[b]) begin
        p = 5'(b);
      end
    end
    return p;
  endfunction

endpackage

// ===== rtl/hpq_if.sv =====
// Operation channel: op and key
interface hpq_in_if #(
  parameter int KW = 32
) ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic signed [KW-1:0] key;

  modport source (output valid, op, key, input ready);
  modport sink   (input valid, op, key, output ready);
endinterface

// Result channel: value, status and count after the operation
interface hpq_out_if #(
  parameter int KW = 32,
  parameter int CW = 11
) ();
  logic                 valid;
  logic                 ready;
  logic signed [KW-1:0] value;
  logic [1:0]           status;
  logic [CW-1:0]        count;

  modport source (output valid, value, status, count, input ready);
  modport sink   (input valid, value, status, count, output ready);
endinterface

// ===== rtl/hpq_ram.sv =====
// Simple dual-port RAM, one write and one registered read port
module hpq_ram #(
  parameter int  W     = 32,
  parameter int  DEPTH = 2,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== rtl/hpq_cell.sv =====
// One tree level of the heap. Holds every slot of its level (a single register at the
// root; below it even slots in one RAM, odd slots in another, addressed by parent index)
// and does the compare-and-swap for a token visiting this level, then hands the token on.
module hpq_cell import hpq_pkg::*; #(
  parameter int KW  = 32,
  parameter int SW  = 11,
  parameter int LW  = 4,
  parameter int LVL = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  // token from the level above
  input  hpq_ctl_t      tin_ctl,
  input  logic [SW-1:0] tin_slot,
  input  logic [SW-1:0] tin_lim,
  input  logic [LW-1:0] tin_dep,
  input  logic [KW-1:0] tin_key,
  // token to the level below
  output hpq_ctl_t      tout_ctl,
  output logic [SW-1:0] tout_slot,
  output logic [SW-1:0] tout_lim,
  output logic [LW-1:0] tout_dep,
  output logic [KW-1:0] tout_key,
  output logic          done_o,
  // child pair read towards the level below
  output logic          cr_en_o,
  output logic [SW-1:0] cr_slot_o,
  input  logic [KW-1:0] cr_a_i,
  input  logic [KW-1:0] cr_b_i,
  // child pair read from the level above
  input  logic          pr_en_i,
  input  logic [SW-1:0] pr_slot_i,
  output logic [KW-1:0] rd_a_o,
  output logic [KW-1:0] rd_b_o,
  // direct read from the controller
  input  logic          dr_en_i,
  input  logic [SW-1:0] dr_slot_i,
  input  logic [LW-1:0] dr_dep_i,
  output logic [KW-1:0] dr_key_o
);
  localparam int DEPTH = (LVL > 0) ? (2 ** LVL) / 2 : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          busy_r;
  hpq_mode_t     mode_r;
  logic [SW-1:0] slot_r;
  logic [SW-1:0] lim_r;
  logic [LW-1:0] dep_r;
  logic [KW-1:0] key_r;
  logic          lex_r, rex_r;
  logic          hit_r, side_r;

  hpq_ctl_t      tout_ctl_r, tout_ctl_nxt;
  logic [SW-1:0] tout_slot_r, tout_slot_nxt;
  logic [SW-1:0] tout_lim_r;
  logic [LW-1:0] tout_dep_r;
  logic [KW-1:0] tout_key_r, tout_key_nxt;

  logic          own_rd, dr_hit, rd_en;
  logic [SW-1:0] rd_slot;
  logic          lex_in, rex_in;
  logic          wr_en;
  logic [KW-1:0] wr_key;
  logic [KW-1:0] own_k, big_k;
  logic          at_tgt, gt, pick_b, move;
  logic [LW-1:0] sh;

  // read port sharing: own slot (insert), children for the level above, direct
  assign own_rd  = tin_ctl.vld && (tin_ctl.mode == MODE_INS);
  assign dr_hit  = dr_en_i && (dr_dep_i == LW'(LVL));
  assign rd_en   = own_rd || pr_en_i || dr_hit;
  assign rd_slot = own_rd ? tin_slot : (pr_en_i ? pr_slot_i : dr_slot_i);

  // children of the hole exist only up to the current count
  assign lex_in = {tin_slot, 1'b0} <= {1'b0, tin_lim};
  assign rex_in = {tin_slot, 1'b1} <= {1'b0, tin_lim};

  assign cr_en_o   = tin_ctl.vld && (tin_ctl.mode == MODE_DN) && lex_in;
  assign cr_slot_o = {tin_slot[SW-2:0], 1'b0};

  // token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      hit_r      <= 1'b0;
      tout_ctl_r <= '{vld: 1'b0, mode: MODE_INS};
    end else begin
      busy_r     <= tin_ctl.vld;
      hit_r      <= dr_hit;
      tout_ctl_r <= tout_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tin_ctl.vld) begin
      mode_r <= tin_ctl.mode;
      slot_r <= tin_slot;
      lim_r  <= tin_lim;
      dep_r  <= tin_dep;
      key_r  <= tin_key;
      lex_r  <= lex_in;
      rex_r  <= rex_in;
    end
    side_r      <= rd_slot[0];
    tout_slot_r <= tout_slot_nxt;
    tout_lim_r  <= lim_r;
    tout_dep_r  <= dep_r;
    tout_key_r  <= tout_key_nxt;
  end

  // compare terms
  assign own_k  = slot_r[0] ? rd_b_o : rd_a_o;
  assign at_tgt = (slot_r == lim_r);
  assign gt     = $signed(key_r) > $signed(own_k);
  assign pick_b = rex_r && ($signed(cr_b_i) > $signed(cr_a_i));
  assign big_k  = pick_b ? cr_b_i : cr_a_i;
  assign move   = lex_r && ($signed(big_k) > $signed(key_r));
  assign sh     = dep_r - LW'(LVL + 1);

  // decide: write this level and pass the token on, or finish here
  always_comb begin
    wr_en         = 1'b0;
    wr_key        = key_r;
    done_o        = 1'b0;
    tout_ctl_nxt  = '{vld: 1'b0, mode: mode_r};
    tout_slot_nxt = slot_r;
    tout_key_nxt  = key_r;
    if (busy_r) begin
      if (mode_r == MODE_INS) begin
        if (at_tgt) begin
          wr_en  = 1'b1;
          done_o = 1'b1;
        end else begin
          // larger key stays here, the other carries on down the path
          wr_en            = gt;
          tout_ctl_nxt.vld = 1'b1;
          tout_slot_nxt    = lim_r >> sh;
          tout_key_nxt     = gt ? own_k : key_r;
        end
      end else begin
        if (move) begin
          wr_en            = 1'b1;
          wr_key           = big_k;
          tout_ctl_nxt.vld = 1'b1;
          tout_slot_nxt    = {slot_r[SW-2:0], pick_b};
        end else begin
          wr_en  = 1'b1;
          done_o = 1'b1;
        end
      end
    end
  end

  // level storage
  if (LVL == 0) begin : g_root
    logic [KW-1:0] root_r;
    logic [KW-1:0] root_q_r;

    always_ff @(posedge clk) begin
      if (wr_en) begin
        root_r <= wr_key;
      end
      if (rd_en) begin
        root_q_r <= root_r;
      end
    end

    assign rd_a_o = root_q_r;
    assign rd_b_o = root_q_r;
  end else begin : g_mem
    logic [AW-1:0] waddr, raddr;

    assign waddr = AW'((slot_r >> 1) & SW'(DEPTH - 1));
    assign raddr = AW'((rd_slot >> 1) & SW'(DEPTH - 1));

    hpq_ram #(.W(KW), .DEPTH(DEPTH)) u_ram_even (
      .clk   (clk),
      .we    (wr_en && !slot_r[0]),
      .waddr (waddr),
      .wdata (wr_key),
      .re    (rd_en),
      .raddr (raddr),
      .rdata (rd_a_o)
    );

    hpq_ram #(.W(KW), .DEPTH(DEPTH)) u_ram_odd (
      .clk   (clk),
      .we    (wr_en && slot_r[0]),
      .waddr (waddr),
      .wdata (wr_key),
      .re    (rd_en),
      .raddr (raddr),
      .rdata (rd_b_o)
    );
  end

  assign tout_ctl  = tout_ctl_r;
  assign tout_slot = tout_slot_r;
  assign tout_lim  = tout_lim_r;
  assign tout_dep  = tout_dep_r;
  assign tout_key  = tout_key_r;
  assign dr_key_o  = hit_r ? (side_r ? rd_b_o : rd_a_o) : '0;
endmodule

// ===== rtl/max_heap_priority_queue_unit.sv =====
// Binary max-heap priority queue, one tree level per cell in a chain. An insert sends a
// token down the path to the new slot; an extract reads the root, then the last key, and
// sifts that key down from the root; a peek, or an extract that empties the queue, only
// reads the root. Empty, full and an unused op go straight to the result. One operation in
// flight; the next is accepted in the cycle after the result loads, which waits for a free
// output register. Synchronous reset empties the queue, keys are not cleared.
module max_heap_priority_queue_unit import hpq_pkg::*; #(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  hpq_in_if.sink     in_chan,
  hpq_out_if.source  out_chan
);
  localparam int KW = KEY_WIDTH;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW;
  localparam int L  = CW;
  localparam int LW = $clog2(L);

  typedef enum logic [2:0] {
    S_IDLE, S_RROOT, S_ROOTD, S_RLAST, S_LASTD, S_WALK, S_FIN
  } state_t;

  state_t        st_r;
  logic [1:0]    op_r;
  logic [CW-1:0] cnt_r;
  logic [KW-1:0] res_value_r;
  hpq_status_t   res_status_r;

  logic          out_vld_r;
  logic [KW-1:0] out_value_r;
  hpq_status_t   out_status_r;
  logic [CW-1:0] out_count_r;

  hpq_ctl_t      lch_ctl_r;
  logic [SW-1:0] lch_slot_r, lch_lim_r;
  logic [LW-1:0] lch_dep_r;
  logic [KW-1:0] lch_key_r;

  logic          dr_en_r;
  logic [SW-1:0] dr_slot_r;
  logic [LW-1:0] dr_dep_r;

  // token links between level cells
  hpq_ctl_t      lk_ctl  [L+1];
  logic [SW-1:0] lk_slot [L+1];
  logic [SW-1:0] lk_lim  [L+1];
  logic [LW-1:0] lk_dep  [L+1];
  logic [KW-1:0] lk_key  [L+1];

  logic          cr_en   [L];
  logic [SW-1:0] cr_slot [L];
  logic [KW-1:0] rd_a    [L];
  logic [KW-1:0] rd_b    [L];
  logic [KW-1:0] dr_key  [L];
  logic [L-1:0]  done_v;
  logic [KW-1:0] dr_key_any;

  assign lk_ctl[0]  = lch_ctl_r;
  assign lk_slot[0] = lch_slot_r;
  assign lk_lim[0]  = lch_lim_r;
  assign lk_dep[0]  = lch_dep_r;
  assign lk_key[0]  = lch_key_r;

  // chain of level cells
  for (genvar i = 0; i < L; i++) begin : g_lvl
    logic          pr_en;
    logic [SW-1:0] pr_slot;
    logic [KW-1:0] ch_a, ch_b;

    if (i == 0) begin : g_top
      assign pr_en   = 1'b0;
      assign pr_slot = '0;
    end else begin : g_mid
      assign pr_en   = cr_en[i-1];
      assign pr_slot = cr_slot[i-1];
    end

    if (i == L - 1) begin : g_leaf
      assign ch_a = '0;
      assign ch_b = '0;
    end else begin : g_inner
      assign ch_a = rd_a[i+1];
      assign ch_b = rd_b[i+1];
    end

    hpq_cell #(.KW(KW), .SW(SW), .LW(LW), .LVL(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .tin_ctl   (lk_ctl[i]),
      .tin_slot  (lk_slot[i]),
      .tin_lim   (lk_lim[i]),
      .tin_dep   (lk_dep[i]),
      .tin_key   (lk_key[i]),
      .tout_ctl  (lk_ctl[i+1]),
      .tout_slot (lk_slot[i+1]),
      .tout_lim  (lk_lim[i+1]),
      .tout_dep  (lk_dep[i+1]),
      .tout_key  (lk_key[i+1]),
      .done_o    (done_v[i]),
      .cr_en_o   (cr_en[i]),
      .cr_slot_o (cr_slot[i]),
      .cr_a_i    (ch_a),
      .cr_b_i    (ch_b),
      .pr_en_i   (pr_en),
      .pr_slot_i (pr_slot),
      .rd_a_o    (rd_a[i]),
      .rd_b_o    (rd_b[i]),
      .dr_en_i   (dr_en_r),
      .dr_slot_i (dr_slot_r),
      .dr_dep_i  (dr_dep_r),
      .dr_key_o  (dr_key[i])
    );
  end

  // only the addressed cell answers a direct read
  always_comb begin
    dr_key_any = '0;
    for (int i = 0; i < L; i++) begin
      dr_key_any = dr_key_any | dr_key[i];
    end
  end

  // operation sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
      lch_ctl_r <= '{vld: 1'b0, mode: MODE_INS};
      dr_en_r   <= 1'b0;
    end else begin
      if (out_vld_r && out_chan.ready && (st_r != S_FIN)) begin
        out_vld_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            op_r         <= in_chan.op;
            res_value_r  <= '0;
            case (in_chan.op) inside
              OP_INSERT: begin
                if (cnt_r == CW'(CAPACITY)) begin
                  res_status_r <= ST_FULL;
                  st_r         <= S_FIN;
                end else begin
                  res_status_r <= ST_OK;
                  cnt_r      <= cnt_r + CW'(1);
                  lch_ctl_r  <= '{vld: 1'b1, mode: MODE_INS};
                  lch_slot_r <= SW'(1);
                  lch_lim_r  <= cnt_r + CW'(1);
                  lch_dep_r  <= LW'(hpq_msb(32'(cnt_r + CW'(1))));
                  lch_key_r  <= in_chan.key;
                  st_r       <= S_WALK;
                end
              end
              OP_EXTRACT, OP_PEEK: begin
                if (cnt_r == '0) begin
                  res_status_r <= ST_EMPTY;
                  st_r         <= S_FIN;
                end else begin
                  res_status_r <= ST_OK;
                  dr_en_r   <= 1'b1;
                  dr_slot_r <= SW'(1);
                  dr_dep_r  <= '0;
                  st_r      <= S_RROOT;
                end
              end
              default: begin
                res_status_r <= ST_OK;
                st_r         <= S_FIN;
              end
            endcase
          end
        end
        S_RROOT: begin
          dr_en_r <= 1'b0;
          st_r    <= S_ROOTD;
        end
        S_ROOTD: begin
          res_value_r <= dr_key_any;
          if (op_r == OP_PEEK) begin
            st_r <= S_FIN;
          end else begin
            cnt_r <= cnt_r - CW'(1);
            if (cnt_r == CW'(1)) begin
              st_r <= S_FIN;
            end else begin
              // fetch the last key, which refills the root
              dr_en_r   <= 1'b1;
              dr_slot_r <= cnt_r;
              dr_dep_r  <= LW'(hpq_msb(32'(cnt_r)));
              st_r      <= S_RLAST;
            end
          end
        end
        S_RLAST: begin
          dr_en_r <= 1'b0;
          st_r    <= S_LASTD;
        end
        S_LASTD: begin
          lch_ctl_r  <= '{vld: 1'b1, mode: MODE_DN};
          lch_slot_r <= SW'(1);
          lch_lim_r  <= cnt_r;
          lch_dep_r  <= '0;
          lch_key_r  <= dr_key_any;
          st_r       <= S_WALK;
        end
        S_WALK: begin
          lch_ctl_r.vld <= 1'b0;
          if (|done_v) begin
            st_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_vld_r || out_chan.ready) begin
            out_vld_r    <= 1'b1;
            out_value_r  <= res_value_r;
            out_status_r <= res_status_r;
            out_count_r  <= cnt_r;
            st_r         <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready   = (st_r == S_IDLE);
  assign out_chan.valid  = out_vld_r;
  assign out_chan.value  = out_value_r;
  assign out_chan.status = out_status_r;
  assign out_chan.count  = out_count_r;

`ifndef SYNTHESIS
  // fill level never passes capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // a single token in the chain finishes in one cell at a time
  a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(done_v))
    else $error("more than one level cell finished together");

  // no token may finish while the sequencer is idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> (done_v == '0))
    else $error("token finished with no operation in flight");

  // a full status only ever comes with a full queue
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status == ST_FULL) |-> (out_chan.count == CW'(CAPACITY)))
    else $error("full status reported below capacity");

  // an accepted transaction always starts work
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (st_r != S_IDLE))
    else $error("transaction accepted but sequencer stayed idle");
`endif
endmodule

// ===== verif/max_heap_priority_queue_unit_test.sv =====
module max_heap_priority_queue_unit_test import hpq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_DEPTH  = 1024;
  localparam int KEY_BITS    = 32;
  localparam int COUNT_BITS  = 11;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 64;

  // op code the block treats as a no-op
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]                 op;
    logic signed [KEY_BITS-1:0] key;
  } heap_op_t;

  typedef struct packed {
    logic signed [KEY_BITS-1:0] value;
    hpq_status_t                status;
    logic [COUNT_BITS-1:0]      count;
  } heap_result_t;

  logic clk;
  logic rst_n;

  hpq_in_if  #(.KW(KEY_BITS))                  in_chan ();
  hpq_out_if #(.KW(KEY_BITS), .CW(COUNT_BITS)) out_chan ();

  max_heap_priority_queue_unit #(
    .CAPACITY (HEAP_DEPTH),
    .KEY_WIDTH(KEY_BITS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n         = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.op    = OP_INSERT;
    in_chan.key   = '0;
    out_chan.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Predicted heap contents, one-based like the block
  logic signed [KEY_BITS-1:0] heap_keys [1:HEAP_DEPTH];
  int unsigned                held = 0;

  heap_op_t     op_backlog [$];
  heap_result_t heap_answers [$];

  int plan_count   = 0;
  int total_items  = 0;
  int ops_accepted = 0;
  int mismatches   = 0;
  int cycle_cnt    = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  // Apply one operation to the predicted heap and work out its result
  task automatic run_heap_op(input logic [1:0] op, input logic signed [KEY_BITS-1:0] key,
                             output heap_result_t res);
    int unsigned                slot;
    int unsigned                kid;
    int unsigned                top;
    logic signed [KEY_BITS-1:0] tmp;
    res.value  = '0;
    res.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (held >= HEAP_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          held++;
          heap_keys[held] = key;
          slot = held;
          // climb while the parent is strictly smaller
          while (slot > 1 && heap_keys[slot] > heap_keys[slot/2]) begin
            tmp               = heap_keys[slot];
            heap_keys[slot]   = heap_keys[slot/2];
            heap_keys[slot/2] = tmp;
            slot              = slot / 2;
          end
        end
      end
      OP_EXTRACT, OP_PEEK: begin
        if (held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.value = heap_keys[1];
          if (op == OP_EXTRACT) begin
            heap_keys[1] = heap_keys[held];
            held--;
            slot = 1;
            // sink the moved key; left child wins a tie
            while (1) begin
              top = slot;
              kid = 2 * slot;
              if (kid <= held && heap_keys[kid] > heap_keys[top]) top = kid;
              if (kid + 1 <= held && heap_keys[kid+1] > heap_keys[top]) top = kid + 1;
              if (top == slot) break;
              tmp             = heap_keys[slot];
              heap_keys[slot] = heap_keys[top];
              heap_keys[top]  = tmp;
              slot            = top;
            end
          end
        end
      end
      default: ;
    endcase
    res.count = COUNT_BITS'(held);
  endtask

  // Stimulus construction, tracking occupancy to steer the mix
  task automatic queue_op(input logic [1:0] op, input logic signed [KEY_BITS-1:0] key);
    heap_op_t item;
    item.op  = op;
    item.key = key;
    op_backlog.insert(op_backlog.size(), item);
    if (op == OP_INSERT && plan_count < HEAP_DEPTH) plan_count++;
    if (op == OP_EXTRACT && plan_count > 0) plan_count--;
  endtask

  function automatic logic signed [KEY_BITS-1:0] rand_key();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return $signed(32'($urandom_range(0, 15))) - 32'sd8;
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic mix_ops(input int n, input int ins_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct) queue_op(OP_INSERT, rand_key());
      else if (r < 96) queue_op(($urandom_range(0, 2) != 0) ? OP_EXTRACT : OP_PEEK, $urandom);
      else queue_op(OP_UNUSED, $urandom);
    end
  endtask

  // Idle pattern: thirds of the run by accepted transactions
  function automatic bit idles_now(input bit receiver);
    int pct;
    if (ops_accepted < total_items / 3) pct = receiver ? 68 : 24;
    else if (ops_accepted < 2 * total_items / 3) pct = receiver ? 24 : 68;
    else pct = 0;
    return $urandom_range(0, 99) < pct;
  endfunction

  // Driver: offer pending operations, predict on acceptance
  always @(posedge clk) begin : drive_ops
    heap_op_t     item;
    heap_result_t answer;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        run_heap_op(in_chan.op, in_chan.key, answer);
        heap_answers.insert(heap_answers.size(), answer);
        ops_accepted++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (op_backlog.size() != 0 && !idles_now(1'b0)) begin
          item = op_backlog.pop_front();
          in_chan.valid <= 1'b1;
          in_chan.op    <= item.op;
          in_chan.key   <= item.key;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // One long result back-pressure early in the last third
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && total_items > 0 && ops_accepted >= 2 * total_items / 3 + 10) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic report_bad(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    heap_result_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (heap_answers.size() == 0) begin
          report_bad($sformatf("unexpected result value=%0d status=%0d count=%0d",
                               out_chan.value, out_chan.status, out_chan.count));
        end else begin
          want = heap_answers.pop_front();
          if (out_chan.value !== want.value || out_chan.status !== want.status ||
              out_chan.count !== want.count) begin
            report_bad($sformatf("value %0d/%0d status %0d/%0d count %0d/%0d (exp/act)",
                                 want.value, out_chan.value, want.status, out_chan.status,
                                 want.count, out_chan.count));
          end
        end
      end
      out_chan.ready <= (hold_left == 0) && !idles_now(1'b1);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[max_heap_priority_queue_unit] ERROR");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    // empty heap, unused op, key extremes and ties
    queue_op(OP_PEEK, $urandom);
    queue_op(OP_EXTRACT, $urandom);
    queue_op(OP_UNUSED, $urandom);
    queue_op(OP_INSERT, 32'sh7FFF_FFFF);
    queue_op(OP_INSERT, 32'sh8000_0000);
    queue_op(OP_INSERT, 32'sd0);
    queue_op(OP_INSERT, -32'sd1);
    queue_op(OP_INSERT, 32'sd1);
    queue_op(OP_INSERT, 32'sh7FFF_FFFF);
    queue_op(OP_INSERT, 32'sh8000_0000);
    queue_op(OP_PEEK, $urandom);
    repeat (4) queue_op(OP_EXTRACT, $urandom);
    queue_op(OP_UNUSED, $urandom);
    queue_op(OP_PEEK, $urandom);
    repeat (3) queue_op(OP_EXTRACT, $urandom);
    queue_op(OP_EXTRACT, $urandom);
    queue_op(OP_PEEK, $urandom);

    mix_ops(20, 55);

    // fill to capacity, with some peeks and extracts on the way
    while (plan_count < HEAP_DEPTH) begin
      case ($urandom_range(0, 63))
        0:       queue_op(OP_PEEK, $urandom);
        1:       queue_op(OP_EXTRACT, $urandom);
        default: queue_op(OP_INSERT, rand_key());
      endcase
    end

    // full heap: dropped inserts, then refill one slot
    repeat (3) queue_op(OP_INSERT, rand_key());
    queue_op(OP_PEEK, $urandom);
    queue_op(OP_EXTRACT, $urandom);
    queue_op(OP_INSERT, rand_key());
    queue_op(OP_INSERT, rand_key());

    // deep sift-downs from a near-full heap, then a balanced tail
    mix_ops(30, 20);
    mix_ops(20, 50);

    total_items = op_backlog.size();

    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (op_backlog.size() != 0 || in_chan.valid) @(posedge clk);
    while (heap_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("[max_heap_priority_queue_unit] OK");
    end else begin
      $display("[max_heap_priority_queue_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== max_heap_priority_queue_unit.f =====
rtl/hpq_pkg.sv
rtl/hpq_if.sv
rtl/hpq_ram.sv
rtl/hpq_cell.sv
rtl/max_heap_priority_queue_unit.sv
verif/max_heap_priority_queue_unit_test.sv
